/* design/stnn_pkg.sv */
package stnn_pkg;

    localparam int MAX_POINTS = 64;
    localparam int VALUE_BITS = 32;

    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int IDX_W  = 6;
    localparam int K_W    = 7;
    localparam int IN_W   = 32;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD_K = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        EM_ACK,
        EM_PLAIN,
        EM_NEIGH
    } t_emit;

    typedef enum logic [3:0] {
        DP_IDLE,
        DP_LOAD,
        DP_CLEAR,
        DP_RD_PREV,
        DP_SHIFT,
        DP_INSERT,
        DP_RD_EDGE,
        DP_RD_MID,
        DP_LO_MID,
        DP_HI_MID,
        DP_POS_MID,
        DP_RD_PAIR,
        DP_POS_LO,
        DP_POS_HI,
        DP_RD_POS,
        DP_RD_GROW
    } t_dp_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_APP_CHK,
        S_APP_CMP,
        S_APP_INS,
        S_EDGE,
        S_BS,
        S_BS_CMP,
        S_PICK,
        S_POS_RD,
        S_NEMIT,
        S_GROW,
        S_GROW_CMP,
        S_GO_LEFT,
        S_GO_RIGHT,
        S_PLAIN
    } t_state;

    // growth steps reuse the datapath op codes below
    localparam t_dp_op DP_GO_LEFT  = DP_LO_MID;
    localparam t_dp_op DP_GO_RIGHT = DP_HI_MID;

    typedef struct packed {
        t_dp_op  op;
        logic    emit;
        t_emit   kind;
        t_status status;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic full;
        logic empty;
        logic k_bad;
        logic k_all;
        logic pos_zero;
        logic a_gt_x;
        logic a_lt_x;
        logic x_le_a;
        logic x_ge_b;
        logic gap;
        logic pick_lo;
        logic lo_zero;
        logic hi_top;
        logic grow_left;
        logic last;
        logic out_free;
    } t_flags;

endpackage

/* design/stnn_ctrl.sv */
module stnn_ctrl
    import stnn_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  t_flags i_flags,
    output logic   o_busy,
    output t_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.op     = DP_IDLE;
        o_cmd.emit   = 1'b0;
        o_cmd.kind   = EM_ACK;
        o_cmd.status = ST_OK;
        o_busy       = (r_state != S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_flags.op)
                    OP_CLEAR: begin
                        if (i_flags.out_free) begin
                            o_cmd.op   = DP_CLEAR;
                            o_cmd.emit = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end
                    OP_APPEND: begin
                        if (!i_flags.full) begin
                            n_state = S_APP_CHK;
                        end else if (i_flags.out_free) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = ST_FULL;
                            n_state      = S_IDLE;
                        end
                    end
                    OP_QUERY: begin
                        if (i_flags.empty) begin
                            if (i_flags.out_free) begin
                                o_cmd.emit   = 1'b1;
                                o_cmd.status = ST_EMPTY;
                                n_state      = S_IDLE;
                            end
                        end else if (i_flags.k_bad) begin
                            if (i_flags.out_free) begin
                                o_cmd.emit   = 1'b1;
                                o_cmd.status = ST_BAD_K;
                                n_state      = S_IDLE;
                            end
                        end else if (i_flags.k_all) begin
                            n_state = S_PLAIN;
                        end else begin
                            o_cmd.op = DP_RD_EDGE;
                            n_state  = S_EDGE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_APP_CHK: begin
                if (i_flags.pos_zero) begin
                    n_state = S_APP_INS;
                end else begin
                    o_cmd.op = DP_RD_PREV;
                    n_state  = S_APP_CMP;
                end
            end
            S_APP_CMP: begin
                if (i_flags.a_gt_x) begin
                    o_cmd.op = DP_SHIFT;
                    n_state  = S_APP_CHK;
                end else begin
                    n_state = S_APP_INS;
                end
            end
            S_APP_INS: begin
                if (i_flags.out_free) begin
                    o_cmd.op   = DP_INSERT;
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_EDGE: begin
                if (i_flags.x_le_a) begin
                    o_cmd.op = DP_POS_LO;
                    n_state  = S_POS_RD;
                end else if (i_flags.x_ge_b) begin
                    o_cmd.op = DP_POS_HI;
                    n_state  = S_POS_RD;
                end else begin
                    n_state = S_BS;
                end
            end
            S_BS: begin
                if (i_flags.gap) begin
                    o_cmd.op = DP_RD_MID;
                    n_state  = S_BS_CMP;
                end else begin
                    o_cmd.op = DP_RD_PAIR;
                    n_state  = S_PICK;
                end
            end
            S_BS_CMP: begin
                if (i_flags.a_lt_x) begin
                    o_cmd.op = DP_LO_MID;
                    n_state  = S_BS;
                end else if (i_flags.a_gt_x) begin
                    o_cmd.op = DP_HI_MID;
                    n_state  = S_BS;
                end else begin
                    o_cmd.op = DP_POS_MID;
                    n_state  = S_POS_RD;
                end
            end
            S_PICK: begin
                o_cmd.op = i_flags.pick_lo ? DP_POS_LO : DP_POS_HI;
                n_state  = S_POS_RD;
            end
            S_POS_RD: begin
                o_cmd.op = DP_RD_POS;
                n_state  = S_NEMIT;
            end
            S_NEMIT: begin
                if (i_flags.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = EM_NEIGH;
                    n_state    = i_flags.last ? S_IDLE : S_GROW;
                end
            end
            S_GROW: begin
                if (i_flags.lo_zero) begin
                    n_state = S_GO_RIGHT;
                end else if (i_flags.hi_top) begin
                    n_state = S_GO_LEFT;
                end else begin
                    o_cmd.op = DP_RD_GROW;
                    n_state  = S_GROW_CMP;
                end
            end
            S_GROW_CMP: begin
                n_state = i_flags.grow_left ? S_GO_LEFT : S_GO_RIGHT;
            end
            S_GO_LEFT: begin
                o_cmd.op = DP_GO_LEFT;
                n_state  = S_POS_RD;
            end
            S_GO_RIGHT: begin
                o_cmd.op = DP_GO_RIGHT;
                n_state  = S_POS_RD;
            end
            S_PLAIN: begin
                if (i_flags.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = EM_PLAIN;
                    n_state    = i_flags.last ? S_IDLE : S_PLAIN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* design/stnn_dp.sv */
module stnn_dp
    import stnn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_grow_step,
    input  logic [1:0]        i_op,
    input  logic signed [IN_W-1:0] i_value,
    input  logic [K_W-1:0]    i_count_wanted,
    input  logic              i_by_distance,
    input  logic              i_out_stall,
    output t_flags            o_flags,
    output logic              o_out_valid,
    output logic [IDX_W-1:0]  o_index,
    output logic              o_last,
    output logic [1:0]        o_status
);

    localparam int VW = VALUE_BITS;

    logic [VW-1:0]     mem_val [MAX_POINTS];
    logic [IDX_W-1:0]  mem_idx [MAX_POINTS];

    t_op               r_op;
    logic [VW-1:0]     r_x;
    logic [K_W-1:0]    r_k;
    logic              r_by;
    logic [CNT_W-1:0]  r_n;
    logic [ADDR_W-1:0] r_pos, r_lo, r_hi, r_mid;
    logic [K_W-1:0]    r_cnt;
    logic [VW-1:0]     r_rd_a, r_rd_b;
    logic [IDX_W-1:0]  r_ridx_a;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_index;
    logic              r_last;
    t_status           r_status;

    logic [CNT_W-1:0]  n_n;
    logic [ADDR_W-1:0] n_pos, n_lo, n_hi;
    logic [K_W-1:0]    n_cnt;

    logic signed [VW-1:0] value_ext;
    logic [VW-1:0]     key_in;
    logic [ADDR_W-1:0] top_addr;
    logic [ADDR_W:0]   lo_hi_sum;
    logic [ADDR_W-1:0] mid;
    logic              rd_en;
    logic [ADDR_W-1:0] addr_a, addr_b;
    logic              wr_en;
    logic [VW-1:0]     wr_val;
    logic [IDX_W-1:0]  wr_idx;
    logic [VW-1:0]     dist_a, dist_b;
    logic              out_free;

    // offset binary: flipping the sign bit makes unsigned order match signed order
    assign value_ext = VW'(i_value);
    assign key_in    = {~value_ext[VW-1], value_ext[VW-2:0]};
    assign top_addr  = ADDR_W'(r_n - 1'b1);
    assign lo_hi_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid       = lo_hi_sum[ADDR_W:1];
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        rd_en  = 1'b1;
        addr_a = r_pos;
        addr_b = r_hi;
        unique case (i_cmd.op)
            DP_RD_PREV: addr_a = r_pos - 1'b1;
            DP_RD_EDGE: begin
                addr_a = '0;
                addr_b = top_addr;
            end
            DP_RD_MID:  addr_a = mid;
            DP_RD_PAIR: addr_a = r_lo;
            DP_RD_POS:  addr_a = r_pos;
            DP_RD_GROW: begin
                addr_a = r_lo - 1'b1;
                addr_b = r_hi + 1'b1;
            end
            default:    rd_en = 1'b0;
        endcase
    end

    assign wr_en  = (i_cmd.op == DP_SHIFT) || (i_cmd.op == DP_INSERT);
    assign wr_val = (i_cmd.op == DP_SHIFT) ? r_rd_a : r_x;
    assign wr_idx = (i_cmd.op == DP_SHIFT) ? r_ridx_a : IDX_W'(r_n);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_val[r_pos] <= wr_val;
            mem_idx[r_pos] <= wr_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_a   <= mem_val[addr_a];
            r_rd_b   <= mem_val[addr_b];
            r_ridx_a <= mem_idx[addr_a];
        end
    end

    always_comb begin
        n_n   = r_n;
        n_pos = r_pos;
        n_lo  = r_lo;
        n_hi  = r_hi;
        n_cnt = r_cnt;
        unique case (i_cmd.op)
            DP_LOAD: begin
                n_pos = ADDR_W'(r_n);
                n_cnt = '0;
            end
            DP_CLEAR:  n_n = '0;
            DP_SHIFT:  n_pos = r_pos - 1'b1;
            DP_INSERT: n_n = r_n + 1'b1;
            DP_RD_EDGE: begin
                n_lo = '0;
                n_hi = top_addr;
            end
            DP_LO_MID: begin
                if (i_grow_step) begin
                    n_lo  = r_lo - 1'b1;
                    n_pos = r_lo - 1'b1;
                end else begin
                    n_lo = r_mid;
                end
            end
            DP_HI_MID: begin
                if (i_grow_step) begin
                    n_hi  = r_hi + 1'b1;
                    n_pos = r_hi + 1'b1;
                end else begin
                    n_hi = r_mid;
                end
            end
            DP_POS_MID: begin
                n_pos = r_mid;
                n_lo  = r_mid;
                n_hi  = r_mid;
            end
            DP_POS_LO: begin
                n_pos = r_lo;
                n_hi  = r_lo;
            end
            DP_POS_HI: begin
                n_pos = r_hi;
                n_lo  = r_hi;
            end
            default: begin
            end
        endcase
        if (i_cmd.emit && (i_cmd.kind != EM_ACK)) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
        end else begin
            r_n <= n_n;
        end
        r_pos <= n_pos;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_cnt <= n_cnt;
        if (i_cmd.op == DP_RD_MID) begin
            r_mid <= mid;
        end
        if (i_cmd.op == DP_LOAD) begin
            r_op <= t_op'(i_op);
            r_x  <= key_in;
            r_k  <= i_count_wanted;
            r_by <= i_by_distance;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_status <= i_cmd.status;
            case (i_cmd.kind)
                EM_PLAIN: begin
                    r_index <= IDX_W'(r_cnt);
                    r_last  <= o_flags.last;
                end
                EM_NEIGH: begin
                    r_index <= r_ridx_a;
                    r_last  <= o_flags.last;
                end
                default: begin
                    r_index <= '0;
                    r_last  <= 1'b1;
                end
            endcase
        end
    end

    assign dist_a = (r_rd_a > r_x) ? (r_rd_a - r_x) : (r_x - r_rd_a);
    assign dist_b = (r_rd_b > r_x) ? (r_rd_b - r_x) : (r_x - r_rd_b);

    always_comb begin
        o_flags.op        = r_op;
        o_flags.full      = (r_n == CNT_W'(MAX_POINTS));
        o_flags.empty     = (r_n == '0);
        o_flags.k_bad     = (r_k == '0) || (r_k > K_W'(r_n));
        o_flags.k_all     = (r_k == K_W'(r_n)) && !r_by;
        o_flags.pos_zero  = (r_pos == '0);
        o_flags.a_gt_x    = (r_rd_a > r_x);
        o_flags.a_lt_x    = (r_rd_a < r_x);
        o_flags.x_le_a    = (r_x <= r_rd_a);
        o_flags.x_ge_b    = (r_x >= r_rd_b);
        o_flags.gap       = ({1'b0, r_hi} > ({1'b0, r_lo} + 1'b1));
        o_flags.pick_lo   = ((r_x - r_rd_a) < (r_rd_b - r_x));
        o_flags.lo_zero   = (r_lo == '0);
        o_flags.hi_top    = (r_hi == top_addr);
        o_flags.grow_left = (dist_a < dist_b);
        o_flags.last      = ((r_cnt + 1'b1) == r_k);
        o_flags.out_free  = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_index     = r_index;
    assign o_last      = r_last;
    assign o_status    = r_status;

endmodule

/* design/sorted_table_nearest_neighbour_top.sv */
// Channel  Direction  Handshake                 Word
// in       input      i_in_valid / o_in_stall   i_op, i_value, i_count_wanted, i_by_distance
// out      output     o_out_valid / i_out_stall o_index, o_last, o_status
//
// One word is worked at a time; o_in_stall is high from acceptance until its last result
// is loaded. Clear and full/empty/bad-k answers are given straight from dispatch. An append
// shifts each larger entry up one slot, then writes the point into the free slot.
// A query binary-searches for the nearest point, then emits it and grows the run one
// neighbour at a time; a plain-order run emits the indices from 0 upward.
// Reset (synchronous, active low) empties the table at once; a stalled output holds its word.
module sorted_table_nearest_neighbour_top
    import stnn_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [1:0]             i_op,
    input  logic signed [IN_W-1:0] i_value,
    input  logic [K_W-1:0]         i_count_wanted,
    input  logic                   i_by_distance,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [IDX_W-1:0]       o_index,
    output logic                   o_last,
    output logic [1:0]             o_status
);

    t_cmd   cmd;
    t_flags flags;
    logic   busy;
    logic   r_grow_step;

    stnn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_flags    (flags),
        .o_busy     (busy),
        .o_cmd      (cmd)
    );

    // lo/hi moves during growth come only after the first neighbour is out;
    // set once the first neighbour is emitted, cleared on every new word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grow_step <= 1'b0;
        end else if (cmd.op == DP_LOAD) begin
            r_grow_step <= 1'b0;
        end else if (cmd.emit && cmd.kind == EM_NEIGH) begin
            r_grow_step <= 1'b1;
        end
    end

    stnn_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_grow_step    (r_grow_step),
        .i_op           (i_op),
        .i_value        (i_value),
        .i_count_wanted (i_count_wanted),
        .i_by_distance  (i_by_distance),
        .i_out_stall    (i_out_stall),
        .o_flags        (flags),
        .o_out_valid    (o_out_valid),
        .o_index        (o_index),
        .o_last         (o_last),
        .o_status       (o_status)
    );

    assign o_in_stall = busy;

endmodule

/* tb/tb.sv */
module tb;
    import stnn_pkg::*;

    typedef logic [VALUE_BITS-1:0] t_key;

    typedef struct packed {
        t_op              op;
        logic [IN_W-1:0]  value;
        logic [K_W-1:0]   k;
        logic             by_dist;
    } t_word;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             last;
        t_status          status;
    } t_answer;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [1:0]             i_op = 2'd0;
    logic signed [IN_W-1:0] i_value = '0;
    logic [K_W-1:0]         i_count_wanted = '0;
    logic                   i_by_distance = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [IDX_W-1:0]       o_index;
    logic                   o_last;
    logic [1:0]             o_status;

    sorted_table_nearest_neighbour_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_value        (i_value),
        .i_count_wanted (i_count_wanted),
        .i_by_distance  (i_by_distance),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_index        (o_index),
        .o_last         (o_last),
        .o_status       (o_status)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

    // pending stimulus and outstanding answers
    t_word   word_q[$];
    t_answer answer_q[$];
    t_word   cur_word;
    t_answer want;
    logic    in_taken = 1'b0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_used = 1'b0;
    int hold_left = 0;

    int mism_cnt = 0;
    int n_queued = 0;
    int n_words = 0;
    int n_ignored = 0;
    int n_checked = 0;
    int n_runs = 0;
    int n_plain = 0;
    int n_full = 0;
    int n_errs = 0;

    // shadow of the point table: keys in offset binary, ascending
    t_key             key_tab [MAX_POINTS];
    logic [IDX_W-1:0] arr_tab [MAX_POINTS];
    int               pt_count = 0;

    function automatic t_key key_of(logic [IN_W-1:0] v);
        logic [63:0] wide;
        wide = {{(64-IN_W){v[IN_W-1]}}, v};
        return wide[VALUE_BITS-1:0] ^ (t_key'(1) << (VALUE_BITS-1));
    endfunction

    function automatic t_key gap(t_key a, t_key b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int nearest_slot(t_key x, int n);
        int lo, hi, mid;
        lo = 0;
        hi = n - 1;
        if (x <= key_tab[0]) return 0;
        if (x >= key_tab[n-1]) return n - 1;
        while (hi > lo + 1) begin
            mid = (lo + hi) / 2;
            if (key_tab[mid] < x) lo = mid;
            else if (key_tab[mid] > x) hi = mid;
            else return mid;
        end
        // equal distance goes to the upper neighbour
        if (x - key_tab[lo] < key_tab[lo+1] - x) return lo;
        return lo + 1;
    endfunction

    task automatic add_answer(logic [IDX_W-1:0] idx, logic last, t_status st);
        t_answer a;
        a.index = idx;
        a.last = last;
        a.status = st;
        answer_q.push_back(a);
    endtask

    task automatic predict_neighbours(t_op op, logic [IN_W-1:0] v, logic [K_W-1:0] kw,
                                      logic bd);
        t_key x;
        int n, k, pos, lo, hi, i;
        x = key_of(v);
        n = pt_count;
        k = int'(kw);
        case (op)
            OP_CLEAR: begin
                pt_count = 0;
                add_answer('0, 1'b1, ST_OK);
            end
            OP_APPEND: begin
                if (n >= MAX_POINTS) begin
                    n_full++;
                    add_answer('0, 1'b1, ST_FULL);
                end else begin
                    pos = n;
                    while (pos > 0 && key_tab[pos-1] > x) begin
                        key_tab[pos] = key_tab[pos-1];
                        arr_tab[pos] = arr_tab[pos-1];
                        pos--;
                    end
                    key_tab[pos] = x;
                    arr_tab[pos] = IDX_W'(n);
                    pt_count = n + 1;
                    add_answer('0, 1'b1, ST_OK);
                end
            end
            OP_QUERY: begin
                if (n == 0) begin
                    n_errs++;
                    add_answer('0, 1'b1, ST_EMPTY);
                end else if (k == 0 || k > n) begin
                    n_errs++;
                    add_answer('0, 1'b1, ST_BAD_K);
                end else if (k == n && !bd) begin
                    n_plain++;
                    for (i = 0; i < n; i++)
                        add_answer(IDX_W'(i), i == n - 1, ST_OK);
                end else begin
                    n_runs++;
                    pos = nearest_slot(x, n);
                    lo = pos;
                    hi = pos;
                    add_answer(arr_tab[pos], k == 1, ST_OK);
                    // grow toward the closer side, ties go right
                    for (i = 1; i < k; i++) begin
                        if (lo == 0) begin
                            hi++;
                            pos = hi;
                        end else if (hi == n - 1) begin
                            lo--;
                            pos = lo;
                        end else if (gap(key_tab[lo-1], x) < gap(key_tab[hi+1], x)) begin
                            lo--;
                            pos = lo;
                        end else begin
                            hi++;
                            pos = hi;
                        end
                        add_answer(arr_tab[pos], i == k - 1, ST_OK);
                    end
                end
            end
            default: n_ignored++;
        endcase
    endtask

    // driver: advance to the next word once the current one is taken
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (word_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                cur_word = word_q.pop_front();
                i_in_valid <= 1'b1;
                i_op <= cur_word.op;
                i_value <= cur_word.value;
                i_count_wanted <= cur_word.k;
                i_by_distance <= cur_word.by_dist;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
    end

    // long receiver hold-off, started once on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_used) begin
            hold_left <= 300;
            hold_used <= 1'b1;
        end
    end

    // monitor: predict on accepted input, check accepted output
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            n_words++;
            predict_neighbours(t_op'(i_op), i_value, i_count_wanted, i_by_distance);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_checked++;
            if (answer_q.size() == 0) begin
                mism_cnt++;
                if (mism_cnt <= 200)
                    $display("%0t: unexpected word index %0d last %0d status %0d",
                             $time, o_index, o_last, o_status);
            end else begin
                want = answer_q.pop_front();
                if (o_index !== want.index || o_last !== want.last ||
                    o_status !== want.status) begin
                    mism_cnt++;
                    if (mism_cnt <= 200)
                        $display("%0t: index/last/status expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 $time, want.index, want.last, want.status,
                                 o_index, o_last, o_status);
                end
            end
        end
    end

    task automatic queue_word(t_op op, logic [IN_W-1:0] v, int k, logic bd);
        t_word w;
        w.op = op;
        w.value = v;
        w.k = K_W'(k);
        w.by_dist = bd;
        word_q.push_back(w);
        if (op != OP_NONE) n_queued++;
    endtask

    // mode 0 full range, 1 small grid (duplicates and ties), 2 extremes
    function automatic logic [IN_W-1:0] pick_value(int mode, bit query);
        logic [IN_W-1:0] v;
        case (mode)
            1: begin
                if (query) v = (int'($urandom_range(0, 40)) - 20) <<< 15;
                else v = (int'($urandom_range(0, 16)) - 8) <<< 16;
            end
            2: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = '0;
                    3: v = '1;
                    default: v = $urandom;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic queue_directed();
        queue_word(OP_QUERY, 32'h0, 0, 1'b0);
        queue_word(OP_QUERY, 32'hFFFF_FFFF, 127, 1'b1);
        queue_word(OP_NONE, $urandom, $urandom_range(0, 127), 1'b1);
        queue_word(OP_APPEND, 32'h7FFF_FFFF, 0, 1'b0);
        queue_word(OP_APPEND, 32'h8000_0000, 127, 1'b1);
        queue_word(OP_APPEND, 32'h0, 0, 1'b0);
        queue_word(OP_APPEND, 32'h0, 0, 1'b0);
        queue_word(OP_APPEND, 32'h0002_0000, 0, 1'b0);
        queue_word(OP_APPEND, 32'hFFFF_FFFF, 0, 1'b0);
        // midway between 0 and 2.0: tie to the upper point
        queue_word(OP_QUERY, 32'h0001_0000, 2, 1'b1);
        queue_word(OP_QUERY, 32'h0, 3, 1'b1);
        queue_word(OP_QUERY, 32'h8000_0000, 1, 1'b1);
        queue_word(OP_QUERY, 32'h7FFF_FFFF, 6, 1'b0);
        queue_word(OP_QUERY, 32'h4000_0000, 6, 1'b1);
        queue_word(OP_QUERY, 32'h0, 0, 1'b1);
        queue_word(OP_QUERY, 32'h0, 7, 1'b1);
        queue_word(OP_QUERY, 32'hFFFF_FFFF, 127, 1'b0);
        queue_word(OP_QUERY, 32'hC000_0000, 2, 1'b1);
        queue_word(OP_QUERY, 32'h0, 64, 1'b0);
        queue_word(OP_CLEAR, 32'hFFFF_FFFF, 127, 1'b1);
        queue_word(OP_QUERY, 32'h0, 1, 1'b1);
        queue_word(OP_APPEND, 32'h5555_5555, 0, 1'b0);
        queue_word(OP_QUERY, 32'h0, 1, 1'b0);
        queue_word(OP_APPEND, 32'hAAAA_AAAA, 0, 1'b0);
        queue_word(OP_QUERY, 32'h0, 2, 1'b1);
    endtask

    task automatic queue_table_set();
        int npts, tbl, nq, mode, j, k, sel;
        queue_word(OP_CLEAR, $urandom, $urandom_range(0, 127), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 11) == 0) npts = MAX_POINTS + $urandom_range(0, 2);
        else npts = $urandom_range(1, 12);
        tbl = (npts > MAX_POINTS) ? MAX_POINTS : npts;
        mode = $urandom_range(0, 3);
        if (mode == 3) mode = 1;
        if ($urandom_range(0, 5) == 0)
            queue_word(OP_QUERY, $urandom, $urandom_range(0, 127),
                       1'($urandom_range(0, 1)));
        for (j = 0; j < npts; j++) begin
            queue_word(OP_APPEND, pick_value(mode, 1'b0), $urandom_range(0, 127),
                       1'($urandom_range(0, 1)));
            if ($urandom_range(0, 24) == 0)
                queue_word(OP_NONE, $urandom, $urandom_range(0, 127),
                           1'($urandom_range(0, 1)));
        end
        nq = $urandom_range(2, 6);
        for (j = 0; j < nq; j++) begin
            sel = $urandom_range(0, 9);
            if (sel < 6) k = $urandom_range(1, (tbl < 8) ? tbl : 8);
            else if (sel < 8) k = tbl;
            else if (sel == 8) k = $urandom_range(0, 1) ? 0 : $urandom_range(tbl + 1, 127);
            else k = $urandom_range(0, 127);
            queue_word(OP_QUERY, pick_value(mode, 1'b1), k, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic fill_to(int target);
        while (n_queued < target)
            queue_table_set();
    endtask

    task automatic drain();
        while (word_q.size() != 0 || i_in_valid || answer_q.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        queue_directed();
        fill_to(140);
        drain();

        send_idle_pct = 57;
        fill_to(250);
        drain();

        // receiver stalls; hold off long while the sender keeps offering
        send_idle_pct = 0;
        recv_stall_pct = 57;
        hold_req = 1'b1;
        fill_to(360);
        drain();

        send_idle_pct = 27;
        recv_stall_pct = 27;
        fill_to(470);
        drain();

        repeat (150) @(posedge i_clk);
        if (answer_q.size() != 0) begin
            mism_cnt++;
            $display("%0t: %0d expected words never arrived", $time, answer_q.size());
        end
        $display("Covered %0d input words (%0d ignored) and %0d output words.",
                 n_words, n_ignored, n_checked);
        $display("Neighbour runs %0d, plain-order runs %0d, full-table appends %0d, %0s %0d",
                 n_runs, n_plain, n_full, "error answers", n_errs);
        if (mism_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
